// ----- rtl/byte_alu_with_decimal_mode_unit_assert.svh -----
// Assertion macros shared by the byte ALU RTL.
`ifndef BYTE_ALU_WITH_DECIMAL_MODE_UNIT_ASSERT_SVH
`define BYTE_ALU_WITH_DECIMAL_MODE_UNIT_ASSERT_SVH

// Check that cons holds in the same cycle as ante; uses clk and rst_n of the host module.
`define BAWD_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define BAWD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/bawd_pkg.sv -----
// Shared types and constants for the byte ALU with decimal mode.
package bawd_pkg;

    typedef enum logic [3:0] {
        CMD_ADC  = 4'd0,
        CMD_SBC  = 4'd1,
        CMD_AND  = 4'd2,
        CMD_OR   = 4'd3,
        CMD_XOR  = 4'd4,
        CMD_CMP  = 4'd5,
        CMD_ASL  = 4'd6,
        CMD_LSR  = 4'd7,
        CMD_ROL  = 4'd8,
        CMD_ROR  = 4'd9,
        CMD_INC  = 4'd10,
        CMD_DEC  = 4'd11,
        CMD_BIT  = 4'd12,
        CMD_PASS = 4'd13
    } cmd_t;

    // Status bit positions
    localparam int unsigned FLAG_C = 0;
    localparam int unsigned FLAG_Z = 1;
    localparam int unsigned FLAG_D = 3;
    localparam int unsigned FLAG_V = 6;
    localparam int unsigned FLAG_N = 7;

    // Decimal adjust constants
    localparam logic [3:0] BCD_LO_ADJ    = 4'h6;
    localparam logic [4:0] BCD_LO_LIMIT  = 5'h0A;
    localparam logic [4:0] BCD_LO_CARRY  = 5'h10;
    localparam logic [8:0] BCD_HI_LIMIT  = 9'h0A0;
    localparam logic [9:0] BCD_HI_ADJ    = 10'h060;

    // Adder result and its flags
    typedef struct packed {
        logic [7:0] sum;
        logic       c;
        logic       z;
        logic       v;
        logic       n;
    } add_res_t;

endpackage

// ----- rtl/bawd_adder.sv -----
// Binary and packed-decimal add/subtract with carry, with flag generation.
module bawd_adder (
    input  logic               [7:0] a,
    input  logic               [7:0] b,
    input  logic                     cin,
    input  logic                     decimal,
    input  logic                     subtract,
    output bawd_pkg::add_res_t       res
);
    import bawd_pkg::*;

    logic [7:0] b_eff;
    logic [8:0] bin_sum;
    logic [7:0] bin_r;
    logic       bin_v;
    logic [4:0] dlo;
    logic [4:0] dlo_adj;
    logic [3:0] dlo_nib;
    logic [8:0] dmid;
    logic [9:0] dfull;
    logic [5:0] slo;
    logic [5:0] slo_tmp;
    logic [5:0] slo_adj;
    logic [9:0] shi;
    logic [9:0] shi_adj;

    // Binary path: subtract adds the ones' complement
    assign b_eff   = subtract ? ~b : b;
    assign bin_sum = {1'b0, a} + {1'b0, b_eff} + {8'd0, cin};
    assign bin_r   = bin_sum[7:0];
    assign bin_v   = (a[7] ^ bin_r[7]) & (b_eff[7] ^ bin_r[7]);

    // Decimal add: low digit adjust, then high digit adjust
    assign dlo     = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, cin};
    assign dlo_nib = dlo[3:0] + BCD_LO_ADJ;
    assign dlo_adj = (dlo >= BCD_LO_LIMIT) ? (BCD_LO_CARRY | {1'b0, dlo_nib}) : dlo;
    assign dmid    = {1'b0, a[7:4], 4'd0} + {1'b0, b[7:4], 4'd0} + {4'd0, dlo_adj};
    assign dfull   = (dmid >= BCD_HI_LIMIT) ? ({1'b0, dmid} + BCD_HI_ADJ) : {1'b0, dmid};

    // Decimal subtract: signed digit tests in two's complement
    assign slo     = {2'b00, a[3:0]} - {2'b00, b[3:0]} + {5'd0, cin} - 6'd1;
    assign slo_tmp = slo - {2'b00, BCD_LO_ADJ};
    assign slo_adj = slo[5] ? {2'b11, slo_tmp[3:0]} : slo;
    assign shi     = {2'b00, a[7:4], 4'd0} - {2'b00, b[7:4], 4'd0}
                   + {{4{slo_adj[5]}}, slo_adj};
    assign shi_adj = shi[9] ? (shi - BCD_HI_ADJ) : shi;

    always_comb
    begin
        res.sum = bin_r;
        res.c   = bin_sum[8];
        res.z   = (bin_r == 8'd0);
        res.v   = bin_v;
        res.n   = bin_r[7];
        if (decimal && subtract)
        begin
            // flags stay binary, only the byte is adjusted
            res.sum = shi_adj[7:0];
        end
        else if (decimal)
        begin
            res.sum = dfull[7:0];
            res.c   = |dfull[9:8];
            res.v   = (a[7] ^ dmid[7]) & (b[7] ^ dmid[7]);
            res.n   = dmid[7];
        end
    end

endmodule

// ----- rtl/bawd_core.sv -----
// Combinational operation decode, logic and shift unit, and flag merge.
module bawd_core (
    input  logic [3:0] command,
    input  logic [7:0] first_operand,
    input  logic [7:0] second_operand,
    input  logic [7:0] status_in,
    output logic [7:0] result_byte,
    output logic [7:0] status_out
);
    import bawd_pkg::*;

    add_res_t   add_res;
    logic       is_sbc;
    logic [7:0] diff;
    logic [7:0] r;
    logic [7:0] st;

    assign is_sbc = (cmd_t'(command) == CMD_SBC);
    assign diff   = first_operand - second_operand;

    bawd_adder u_adder (
        .a        (first_operand),
        .b        (second_operand),
        .cin      (status_in[FLAG_C]),
        .decimal  (status_in[FLAG_D]),
        .subtract (is_sbc),
        .res      (add_res)
    );

    always_comb
    begin
        r  = first_operand;
        st = status_in;
        case (cmd_t'(command))
            CMD_ADC, CMD_SBC:
            begin
                r         = add_res.sum;
                st[FLAG_C] = add_res.c;
                st[FLAG_Z] = add_res.z;
                st[FLAG_V] = add_res.v;
                st[FLAG_N] = add_res.n;
            end
            CMD_AND:  r = first_operand & second_operand;
            CMD_OR:   r = first_operand | second_operand;
            CMD_XOR:  r = first_operand ^ second_operand;
            CMD_CMP:  st[FLAG_C] = (first_operand >= second_operand);
            CMD_ASL:
            begin
                r          = {second_operand[6:0], 1'b0};
                st[FLAG_C] = second_operand[7];
            end
            CMD_LSR:
            begin
                r          = {1'b0, second_operand[7:1]};
                st[FLAG_C] = second_operand[0];
            end
            CMD_ROL:
            begin
                r          = {second_operand[6:0], status_in[FLAG_C]};
                st[FLAG_C] = second_operand[7];
            end
            CMD_ROR:
            begin
                r          = {status_in[FLAG_C], second_operand[7:1]};
                st[FLAG_C] = second_operand[0];
            end
            CMD_INC:  r = second_operand + 8'd1;
            CMD_DEC:  r = second_operand - 8'd1;
            CMD_BIT:
            begin
                st[FLAG_N] = second_operand[7];
                st[FLAG_V] = second_operand[6];
                st[FLAG_Z] = ((first_operand & second_operand) == 8'd0);
            end
            CMD_PASS: r = second_operand;
            default:  r = first_operand;
        endcase

        // N and Z from the result byte for logic, shift, count and pass; from the difference for compare
        case (cmd_t'(command))
            CMD_AND, CMD_OR, CMD_XOR, CMD_ASL, CMD_LSR, CMD_ROL, CMD_ROR,
            CMD_INC, CMD_DEC, CMD_PASS:
            begin
                st[FLAG_Z] = (r == 8'd0);
                st[FLAG_N] = r[7];
            end
            CMD_CMP:
            begin
                st[FLAG_Z] = (diff == 8'd0);
                st[FLAG_N] = diff[7];
            end
            default:
            begin
                st = st;
            end
        endcase
    end

    assign result_byte = r;
    assign status_out  = st;

endmodule

// ----- rtl/byte_alu_with_decimal_mode_unit.sv -----
// Top level of the 8-bit ALU with binary and packed-decimal add/subtract.
// Path: an accepted beat is registered in the input stage, then in the result stage, which drives done.
// Throughput: one operation per cycle; busy is always low, so start may stay high.
// Stages: input register, one pass of ALU logic (the decimal adder sets the path), result register.
// Reset: rst_n asynchronously clears the valid and done strobes; payload registers are not reset.
// Results appear for exactly one cycle with done high; the receiver has no way to stall them.
`include "byte_alu_with_decimal_mode_unit_assert.svh"

module byte_alu_with_decimal_mode_unit (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [3:0] command,
    input  logic [7:0] first_operand,
    input  logic [7:0] second_operand,
    input  logic [7:0] status_in,
    output logic       done,
    output logic [7:0] result_byte,
    output logic [7:0] status_out
);
    import bawd_pkg::*;

    // Input stage
    logic       in_valid_reg;
    logic       in_valid_next;
    logic [3:0] cmd_reg;
    logic [7:0] a_reg;
    logic [7:0] b_reg;
    logic [7:0] st_reg;

    // Result stage
    logic       done_reg;
    logic [7:0] result_reg;
    logic [7:0] result_next;
    logic [7:0] status_reg;
    logic [7:0] status_next;

    // Every cycle can take a new beat: the pipeline never backs up.
    assign busy          = 1'b0;
    assign in_valid_next = start && !busy;

    // Hold the strobes under asynchronous reset; advance them every cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            done_reg     <= in_valid_reg;
        end
    end

    // Capture the operands of an accepted beat; hold them otherwise.
    always_ff @(posedge clk)
    begin
        if (in_valid_next)
        begin
            cmd_reg <= command;
            a_reg   <= first_operand;
            b_reg   <= second_operand;
            st_reg  <= status_in;
        end
    end

    // One pass through the ALU between the two register stages.
    bawd_core u_core (
        .command        (cmd_reg),
        .first_operand  (a_reg),
        .second_operand (b_reg),
        .status_in      (st_reg),
        .result_byte    (result_next),
        .status_out     (status_next)
    );

    // Load the result only when a beat is in the input stage.
    always_ff @(posedge clk)
    begin
        if (in_valid_reg)
        begin
            result_reg <= result_next;
            status_reg <= status_next;
        end
    end

    assign done        = done_reg;
    assign result_byte = result_reg;
    assign status_out  = status_reg;

    // Every accepted beat produces exactly one done strobe, once it has passed the input and result registers.
    `BAWD_ASSERT_NEXT(a_accept_done, start && !busy, ##1 done, "accepted beat lost")
    `BAWD_ASSERT_SAME(a_done_accept, done, $past(start && !busy, 2), "done without a beat")
    // Decimal and unused status bits pass through untouched.
    `BAWD_ASSERT_SAME(a_status_pass, done, (status_out[5:2] == $past(status_in[5:2], 2)), "status passthrough broken")
    // Compare and bit test return the first operand.
    `BAWD_ASSERT_SAME(a_cmp_bit_keep, done && ($past(command, 2) == CMD_CMP || $past(command, 2) == CMD_BIT), result_byte == $past(first_operand, 2), "cmp or bit altered the byte")

endmodule
